### rtl/core/pfnv_pkg.sv
package pfnv_pkg;

    localparam int MUL_W = 33;

    localparam logic [31:0] SEED_BASE = 32'h6d2b_79f5;
    localparam logic [31:0] SEED_MUL  = 32'h9e37_79b9;

    localparam logic [16:0] Q_ONE   = 17'd65536;
    localparam logic [15:0] Q_INV63 = 16'd1040;

    localparam int KEY_BITS = 6;

    localparam logic signed [18:0] OUT_MAX = 19'sd65535;
    localparam logic signed [18:0] OUT_MIN = -19'sd65536;

    localparam logic [15:0] GAIN_RESET = 16'd24576;
    localparam logic [15:0] IMF_RESET  = 16'd26;

    typedef enum logic
    {
        CFG_OUT_GAIN     = 1'b0,
        CFG_INV_MAX_FREQ = 1'b1
    } cfg_index_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        begin
            y = x ^ (x << 13);
            y = y ^ (y >> 17);
            y = y ^ (y << 5);
            return y;
        end
    endfunction

endpackage

### rtl/core/pitched_filtered_noise_voice.sv
// Noise voice: a sample item (mode 0) steps a xorshift32 generator, runs its
// upper halfword through a one-pole lowpass whose coefficient follows the
// frequency, and returns one signed Q1.16 sample scaled by the output gain and a
// key shaped boost, saturated to 17 bits. A reseed item (mode 1) reloads the
// generator from seed_salt, clears the filter and returns nothing. All
// products run through one 33x33 signed multiplier under a small sequencer,
// one pass per cycle: a sample item makes six passes (scale, coefficient,
// level, shape, gain, output) and a reseed item makes one (seed); a new item
// is taken only when the sequencer is back in idle. One item is in work at a
// time; the finished sample sits in an output register, so the next item is
// taken while it waits, and a second sample holds in its last pass until that
// register is free. Config registers are always ready and take effect at the
// next pass that reads them.
module pitched_filtered_noise_voice
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [30:0] frequency,
    input  logic [7:0]  pitch_key,
    input  logic [31:0] seed_salt,

    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [16:0] noise_out,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_SEED,
        ST_SCALE,
        ST_COEF,
        ST_LEVEL,
        ST_SHAPE,
        ST_GAIN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] gain_reg, gain_next;
    logic [15:0] imf_reg, imf_next;
    logic [31:0] gen_reg, gen_next;
    logic signed [17:0] level_reg, level_next;

    logic [30:0] freq_reg, freq_next;
    logic [5:0]  key_reg, key_next;
    logic [31:0] salt_reg, salt_next;
    logic [16:0] s_reg, s_next;
    logic [16:0] a_reg, a_next;
    logic [17:0] shape_reg, shape_next;
    logic signed [17:0] g_reg, g_next;

    logic        out_valid_reg, out_valid_next;
    logic signed [16:0] out_reg, out_next;

    logic signed [pfnv_pkg::MUL_W-1:0]   mul_a;
    logic signed [pfnv_pkg::MUL_W-1:0]   mul_b;
    logic signed [2*pfnv_pkg::MUL_W-1:0] prod;
    logic signed [2*pfnv_pkg::MUL_W-1:0] prod_q;

    logic signed [16:0] noise;
    logic signed [18:0] diff;
    logic signed [18:0] level_sum;
    logic [15:0] d_val;
    logic [15:0] s_half;
    logic [31:0] seed_word;
    logic signed [18:0] r_val;
    logic        accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign noise_out = out_reg;
    assign cfg_ready = 1'b1;

    assign noise     = $signed({gen_reg[31:16], 1'b0});
    assign diff      = 19'(noise) - 19'(level_reg);
    assign s_half    = s_reg[16:1];
    assign d_val     = {~key_reg, 10'b0} + {6'b0, ~key_reg, 4'b0};
    assign prod      = mul_a * mul_b;
    assign prod_q    = prod >>> 16;
    assign level_sum = 19'(level_reg) + prod_q[18:0];
    assign seed_word = pfnv_pkg::SEED_BASE ^ prod[31:0];
    assign r_val     = prod_q[18:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SEED:
            begin
                mul_a = {1'b0, salt_reg};
                mul_b = {1'b0, pfnv_pkg::SEED_MUL};
            end
            ST_SCALE:
            begin
                mul_a = {2'b0, freq_reg};
                mul_b = {17'b0, imf_reg};
            end
            ST_COEF:
            begin
                mul_a = {16'b0, s_reg};
                mul_b = {16'b0, pfnv_pkg::Q_ONE - {1'b0, s_half}};
            end
            ST_LEVEL:
            begin
                mul_a = {16'b0, a_reg};
                mul_b = {{14{diff[18]}}, diff};
            end
            ST_SHAPE:
            begin
                mul_a = {17'b0, d_val};
                mul_b = {17'b0, d_val};
            end
            ST_GAIN:
            begin
                mul_a = {{15{level_reg[17]}}, level_reg};
                mul_b = {17'b0, gain_reg};
            end
            ST_OUT:
            begin
                mul_a = {{15{g_reg[17]}}, g_reg};
                mul_b = {15'b0, shape_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        imf_next       = imf_reg;
        gen_next       = gen_reg;
        level_next     = level_reg;
        freq_next      = freq_reg;
        key_next       = key_reg;
        salt_next      = salt_reg;
        s_next         = s_reg;
        a_next         = a_reg;
        shape_next     = shape_reg;
        g_next         = g_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (pfnv_pkg::cfg_index_t'(cfg_index))
                pfnv_pkg::CFG_OUT_GAIN:     gain_next = cfg_data;
                pfnv_pkg::CFG_INV_MAX_FREQ: imf_next  = cfg_data;
                default:                    gain_next = gain_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    freq_next  = frequency;
                    key_next   = pitch_key[pfnv_pkg::KEY_BITS-1:0];
                    salt_next  = seed_salt;
                    state_next = mode ? ST_SEED : ST_SCALE;
                end
            end
            ST_SEED:
            begin
                gen_next   = (seed_word == '0) ? 32'd1 : seed_word;
                level_next = '0;
                state_next = ST_IDLE;
            end
            ST_SCALE:
            begin
                gen_next   = pfnv_pkg::xorshift32(gen_reg);
                s_next     = (prod_q > 66'sd65536) ? pfnv_pkg::Q_ONE : prod_q[16:0];
                state_next = ST_COEF;
            end
            ST_COEF:
            begin
                a_next     = prod_q[16:0];
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next = level_sum[17:0];
                state_next = ST_SHAPE;
            end
            ST_SHAPE:
            begin
                shape_next = {1'b0, pfnv_pkg::Q_ONE} + {2'b0, prod_q[15:0]};
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                g_next     = prod_q[17:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (r_val > pfnv_pkg::OUT_MAX)
                    begin
                        out_next = pfnv_pkg::OUT_MAX[16:0];
                    end
                    else if (r_val < pfnv_pkg::OUT_MIN)
                    begin
                        out_next = pfnv_pkg::OUT_MIN[16:0];
                    end
                    else
                    begin
                        out_next = r_val[16:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_reg      <= pfnv_pkg::GAIN_RESET;
            imf_reg       <= pfnv_pkg::IMF_RESET;
            gen_reg       <= pfnv_pkg::SEED_BASE;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            imf_reg       <= imf_next;
            gen_reg       <= gen_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg  <= freq_next;
        key_reg   <= key_next;
        salt_reg  <= salt_next;
        s_reg     <= s_next;
        a_reg     <= a_next;
        shape_reg <= shape_next;
        g_reg     <= g_next;
    end

    // xorshift never reaches zero from a nonzero word
    assert property (@(posedge clk) disable iff (!rst_n) gen_reg != '0)
        else $error("generator word is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg >= -18'sd65536) && (level_reg <= 18'sd65535))
        else $error("filter level out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COEF) |-> (s_reg <= pfnv_pkg::Q_ONE))
        else $error("scale above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result without a finished sample item");

endmodule

### test/pfnv_noise_checker.sv
package pfnv_tb_pkg;

    typedef enum logic
    {
        MODE_SAMPLE = 1'b0,
        MODE_RESEED = 1'b1
    } noise_mode_t;

endpackage

module pfnv_noise_checker
    import pfnv_pkg::*;
    import pfnv_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic [30:0]        frequency,
    input  logic [7:0]         pitch_key,
    input  logic [31:0]        seed_salt,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [16:0] noise_out,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 pending,
    output int                 fail_count
);

    localparam longint ONE_Q   = Q_ONE;
    localparam longint HALF_Q  = 32768;
    localparam longint INV63_Q = Q_INV63;
    localparam longint KEY_TOP = (1 << KEY_BITS) - 1;
    localparam longint SAT_HI  = OUT_MAX;
    localparam longint SAT_LO  = OUT_MIN;

    longint            gain;
    longint            inv_max_freq;
    logic [31:0]       gen_word;
    longint            level;
    logic signed [16:0] noise_expect_q[$];

    // Q16.16 product, floor rounding
    function automatic longint mul_q16(input longint x, input longint y);
        return (x * y) >>> 16;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        longint             f;
        longint             k;
        longint             s;
        longint             a;
        longint             noise;
        longint             d;
        longint             shape;
        longint             r;
        logic [31:0]        x;
        logic [31:0]        w;
        logic signed [16:0] exp_sample;
        if (!rst_n)
        begin
            gain         = GAIN_RESET;
            inv_max_freq = IMF_RESET;
            gen_word     = SEED_BASE;
            level        = 0;
            fail_count   = 0;
            noise_expect_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OUT_GAIN)
                    gain = cfg_data;
                else
                    inv_max_freq = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (noise_expect_q.size() == 0)
                begin
                    $error("noise_out unexpected item, actual %0d", noise_out);
                    fail_count++;
                end
                else
                begin
                    exp_sample = noise_expect_q.pop_front();
                    if (noise_out !== exp_sample)
                    begin
                        $error("noise_out expected %0d actual %0d", exp_sample, noise_out);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_RESEED)
                begin
                    w        = SEED_BASE ^ (seed_salt * SEED_MUL);
                    gen_word = (w == 32'd0) ? 32'd1 : w;
                    level    = 0;
                end
                else
                begin
                    x = gen_word;
                    x = x ^ (x << 13);
                    x = x ^ (x >> 17);
                    x = x ^ (x << 5);
                    gen_word = x;
                    noise = longint'($signed(x[31:16])) * 2;

                    f = frequency;
                    s = mul_q16(f, inv_max_freq);
                    if (s > ONE_Q)
                        s = ONE_Q;
                    a = mul_q16(s, ONE_Q - mul_q16(HALF_Q, s));
                    level = level + mul_q16(a, noise - level);

                    k     = pitch_key[KEY_BITS-1:0];
                    d     = (KEY_TOP - k) * INV63_Q;
                    shape = ONE_Q + mul_q16(d, d);
                    r     = mul_q16(mul_q16(level, gain), shape);
                    if (r > SAT_HI)
                        r = SAT_HI;
                    if (r < SAT_LO)
                        r = SAT_LO;
                    noise_expect_q.push_back(r[16:0]);
                end
            end
        end
        pending = noise_expect_q.size();
    end

endmodule

### test/pitched_filtered_noise_voice_tb.sv
module pitched_filtered_noise_voice_tb;

    import pfnv_pkg::*;
    import pfnv_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [30:0]        frequency;
    logic [7:0]         pitch_key;
    logic [31:0]        seed_salt;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] noise_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    int pending;
    int fail_count;
    int cycle_count = 0;
    bit long_hold   = 1'b0;
    bit calm        = 1'b0;

    pitched_filtered_noise_voice dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .frequency (frequency),
        .pitch_key (pitch_key),
        .seed_salt (seed_salt),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .noise_out (noise_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfnv_noise_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .frequency  (frequency),
        .pitch_key  (pitch_key),
        .seed_salt  (seed_salt),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .noise_out  (noise_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[pitched_filtered_noise_voice] ERROR");
            $finish;
        end
    end

    // output side: random stall bursts, one long hold-off, none when calm
    initial
    begin : sample_sink
        int n;
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 13);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_item(input noise_mode_t m, input logic [30:0] f,
                             input logic [7:0] k, input logic [31:0] salt);
        mode      <= m;
        frequency <= f;
        pitch_key <= k;
        seed_salt <= salt;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_random_item;
        logic [30:0] f;
        case ($urandom_range(0, 2))
            0:       f = 31'($urandom);
            1:       f = 31'($urandom_range(0, 3000 << 16));
            default: f = 31'($urandom_range(0, 1 << 17));
        endcase
        send_item(($urandom_range(0, 9) == 0) ? MODE_RESEED : MODE_SAMPLE,
                  f, 8'($urandom), $urandom);
    endtask

    task automatic write_config(input logic [15:0] gain, input logic [15:0] imf);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_OUT_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_INV_MAX_FREQ;
        cfg_data  <= imf;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain: all samples back, then room for a trailing reseed
    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] inv;
        logic [31:0] zero_salt;
        logic [15:0] gains [PHASES] = '{24576, 65535, 0, 24576, 24576, 0, 0, 40000};
        logic [15:0] imfs [PHASES]  = '{26, 26, 26, 0, 65535, 0, 0, 40};
        int          counts [PHASES] = '{150, 100, 50, 50, 80, 100, 100, 120};

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= MODE_SAMPLE;
        frequency <= '0;
        pitch_key <= '0;
        seed_salt <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_OUT_GAIN;
        cfg_data  <= '0;

        // salt whose seed word comes out zero
        inv = SEED_MUL;
        repeat (5) inv = inv * (32'd2 - SEED_MUL * inv);
        zero_salt = SEED_BASE * inv;

        gains[5] = 16'($urandom);
        imfs[5]  = 16'($urandom);
        gains[6] = 16'($urandom);
        imfs[6]  = 16'($urandom_range(0, 64));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_SAMPLE, 31'd0, 8'd0, 32'd0);
        send_item(MODE_SAMPLE, 31'h7fffffff, 8'd63, 32'hffffffff);
        send_item(MODE_SAMPLE, 31'(2489 << 16), 8'd0, 32'd0);
        send_item(MODE_SAMPLE, 31'(1000 << 16), 8'd64, 32'd0);
        send_item(MODE_SAMPLE, 31'h7fffffff, 8'd255, 32'd0);
        send_item(MODE_SAMPLE, 31'd1, 8'd128, 32'd0);
        send_item(MODE_RESEED, 31'd0, 8'd0, 32'd0);
        repeat (3) send_item(MODE_SAMPLE, 31'h7fffffff, 8'd0, 32'd0);
        send_item(MODE_RESEED, 31'd0, 8'd0, zero_salt);
        repeat (4) send_item(MODE_SAMPLE, 31'h7fffffff, 8'd0, 32'd0);
        send_item(MODE_RESEED, 31'h7fffffff, 8'd255, 32'hffffffff);
        send_item(MODE_SAMPLE, 31'h40000000, 8'd32, 32'd0);
        send_item(MODE_SAMPLE, 31'(500 << 16), 8'd1, 32'd0);
        settle;

        for (int p = 0; p < PHASES; p++)
        begin
            write_config(gains[p], imfs[p]);
            if (p == 1)
                long_hold = 1'b1;
            if (p == PHASES - 1)
                calm = 1'b1;
            repeat (counts[p]) send_random_item;
            settle;
        end

        if (fail_count == 0)
            $display("[pitched_filtered_noise_voice] OK");
        else
            $display("[pitched_filtered_noise_voice] ERROR");
        $finish;
    end

endmodule
